### sv/msdec_pkg.sv
// Shared types, constants and the Morse code table for the symbol-pair decoder.
// No dependencies; imported by every module of the block.
package msdec_pkg;

  localparam int CODE_BITS = 12;
  localparam int CODE_SYMS = CODE_BITS / 2;
  localparam int SLOTS     = 4;
  localparam int Q_DEPTH   = 4;

  localparam logic [1:0] SYM_END   = 2'b00;
  localparam logic [1:0] SYM_DASH  = 2'b01;
  localparam logic [1:0] SYM_DOT   = 2'b10;
  localparam logic [1:0] SYM_SPACE = 2'b11;

  localparam logic [6:0] CH_SPACE = 7'h20;

  typedef logic [CODE_BITS-1:0]             code_t;
  typedef logic [$clog2(CODE_SYMS+1)-1:0]   scount_t;
  typedef logic [$clog2(Q_DEPTH)-1:0]       qptr_t;
  typedef logic [$clog2(Q_DEPTH+1)-1:0]     qcnt_t;

  typedef struct packed {
    logic [SLOTS-1:0]             space;
    logic [SLOTS-1:0]             term;
    logic [SLOTS-1:0][CODE_BITS-1:0] code;
  } sym_entry_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] ch;
  } lookup_t;

  function automatic lookup_t code_lookup(input code_t code);
    lookup_t r;
    r.hit = 1'b1;
    r.ch  = 7'h00;
    case (code)
      12'h009: r.ch = 7'h41;
      12'h06A: r.ch = 7'h42;
      12'h066: r.ch = 7'h43;
      12'h01A: r.ch = 7'h44;
      12'h002: r.ch = 7'h45;
      12'h0A6: r.ch = 7'h46;
      12'h016: r.ch = 7'h47;
      12'h0AA: r.ch = 7'h48;
      12'h00A: r.ch = 7'h49;
      12'h095: r.ch = 7'h4A;
      12'h019: r.ch = 7'h4B;
      12'h09A: r.ch = 7'h4C;
      12'h005: r.ch = 7'h4D;
      12'h006: r.ch = 7'h4E;
      12'h015: r.ch = 7'h4F;
      12'h096: r.ch = 7'h50;
      12'h059: r.ch = 7'h51;
      12'h026: r.ch = 7'h52;
      12'h02A: r.ch = 7'h53;
      12'h001: r.ch = 7'h54;
      12'h029: r.ch = 7'h55;
      12'h0A9: r.ch = 7'h56;
      12'h025: r.ch = 7'h57;
      12'h069: r.ch = 7'h58;
      12'h065: r.ch = 7'h59;
      12'h05A: r.ch = 7'h5A;
      12'h155: r.ch = 7'h30;
      12'h255: r.ch = 7'h31;
      12'h295: r.ch = 7'h32;
      12'h2A5: r.ch = 7'h33;
      12'h2A9: r.ch = 7'h34;
      12'h2AA: r.ch = 7'h35;
      12'h1AA: r.ch = 7'h36;
      12'h16A: r.ch = 7'h37;
      12'h15A: r.ch = 7'h38;
      12'h156: r.ch = 7'h39;
      12'h999: r.ch = 7'h2E;
      12'h5A5: r.ch = 7'h2C;
      12'h9A6: r.ch = 7'h22;
      12'h956: r.ch = 7'h27;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### sv/msdec_front.sv
// Front end: splits each byte into four symbols and runs the code accumulator.
// Depends on msdec_pkg.
module msdec_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc_en,
  input  logic [7:0]            code_byte,
  output msdec_pkg::sym_entry_t entry
);
  import msdec_pkg::*;

  code_t   acc_r, acc_nxt;
  scount_t cnt_r, cnt_nxt;

  always_comb begin
    logic [1:0] sym;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    entry   = '0;
    for (int j = 0; j < SLOTS; j++) begin
      sym = code_byte[7-2*j -: 2];
      entry.code[j] = acc_nxt;
      case (sym)
        SYM_DOT, SYM_DASH: begin
          if (cnt_nxt < scount_t'(CODE_SYMS)) begin
            acc_nxt = {acc_nxt[CODE_BITS-3:0], sym};
            cnt_nxt = cnt_nxt + scount_t'(1);
          end
        end
        SYM_END: begin
          entry.term[j] = 1'b1;
          acc_nxt = '0;
          cnt_nxt = '0;
        end
        default: begin
          entry.space[j] = 1'b1;
          acc_nxt = '0;
          cnt_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else if (acc_en) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### sv/msdec_queue.sv
// Short queue of symbol entries between front and back.
// Depends on msdec_pkg.
module msdec_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  msdec_pkg::sym_entry_t push_data,
  input  logic                  pop,
  output msdec_pkg::sym_entry_t head,
  output logic                  empty,
  output logic                  full
);
  import msdec_pkg::*;

  sym_entry_t mem_r [Q_DEPTH];
  qptr_t      wr_ptr_r, rd_ptr_r;
  qcnt_t      cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == qcnt_t'(Q_DEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + qptr_t'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + qptr_t'(1);
      end
      cnt_r <= cnt_r + qcnt_t'(push) - qcnt_t'(pop);
    end
  end

endmodule

### sv/msdec_back.sv
// Back end: looks up the codes of one entry and sends its characters one per cycle while out_tready is high.
// Depends on msdec_pkg.
module msdec_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  msdec_pkg::sym_entry_t head,
  input  logic                  empty,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [6:0]            out_char,
  output logic                  out_last
);
  import msdec_pkg::*;

  logic [SLOTS-1:0]      work_vld_r, work_vld_nxt;
  logic [SLOTS-1:0][6:0] work_ch_r, work_ch_nxt;
  logic                  ovld_r, ovld_nxt;
  logic [6:0]            och_r, och_nxt;
  logic                  olast_r, olast_nxt;

  logic [SLOTS-1:0]      new_vld;
  logic [SLOTS-1:0][6:0] new_ch;
  logic [SLOTS-1:0]      rem;
  logic [6:0]            sel_ch;
  logic                  emit_ok, emit;
  lookup_t               lk;

  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      lk = code_lookup(head.code[j]);
      new_vld[j] = head.space[j] | (head.term[j] & lk.hit);
      new_ch[j]  = head.space[j] ? CH_SPACE : lk.ch;
    end
  end

  always_comb begin
    rem    = work_vld_r;
    sel_ch = work_ch_r[0];
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (work_vld_r[j]) begin
        sel_ch = work_ch_r[j];
        rem    = work_vld_r & ~(SLOTS'(1) << j);
      end
    end
  end

  assign emit_ok = !ovld_r || out_tready;
  assign emit    = emit_ok && (work_vld_r != '0);
  assign pop     = !empty && ((work_vld_r == '0) || (emit && (rem == '0)));

  always_comb begin
    work_vld_nxt = work_vld_r;
    work_ch_nxt  = work_ch_r;
    ovld_nxt     = ovld_r && !out_tready;
    och_nxt      = och_r;
    olast_nxt    = olast_r;
    if (emit) begin
      work_vld_nxt = rem;
      ovld_nxt     = 1'b1;
      och_nxt      = sel_ch;
      olast_nxt    = (rem == '0);
    end
    if (pop) begin
      work_vld_nxt = new_vld;
      work_ch_nxt  = new_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_vld_r <= '0;
      ovld_r     <= 1'b0;
    end else begin
      work_vld_r <= work_vld_nxt;
      ovld_r     <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_ch_r <= work_ch_nxt;
    och_r     <= och_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_char   = och_r;
  assign out_last   = olast_r;

endmodule

### sv/morse_symbol_pair_decoder_core.sv
// Morse symbol-pair decoder top level: front end, four-entry queue, back end.
// A byte's entry goes from the queue into the back-end work registers, then its first
// character into the output register. Throughput: one byte per cycle while out_tready
// is high and a byte yields at most one character; else the single-character output register limits it.
// Reset: synchronous active-low rst_n clears accumulator, queue and output valid.
module morse_symbol_pair_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] code_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] character, [7] zero
  output logic       out_tlast   // last_of_byte
);
  import msdec_pkg::*;

  sym_entry_t entry, head;
  logic       q_full, q_empty, q_pop, in_xfer;
  logic [6:0] out_char;

  assign in_tready = !q_full;
  assign in_xfer   = in_tvalid && in_tready;

  msdec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc_en    (in_xfer),
    .code_byte (in_tdata),
    .entry     (entry)
  );

  msdec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_data (entry),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  msdec_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (out_char),
    .out_last   (out_tlast)
  );

  assign out_tdata = {1'b0, out_char};

endmodule
